// File: rtl/gfig_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfig_pkg: shared types and constants of the fan index generator
// Widths of the vertex indices, the command passed from front to back and
// the register index codes.
// ----------------------------------------------------------------------------
package gfig_pkg;

  localparam int IDX_W      = 21;   // vertex index width, indices wrap mod 2^21
  localparam int OFS_W      = 9;    // fan_x / fan_z width
  localparam int LOD_W      = 3;    // core_lod width
  localparam int GW_W       = 13;   // grid_width register width
  localparam int PS_W       = 9;    // patch_size register width
  localparam int STEP_W     = 8;    // core step 2^core_lod, up to 128
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = 1;

  localparam logic [GW_W-1:0] GRID_WIDTH_RST = GW_W'(257);
  localparam logic [PS_W-1:0] PATCH_SIZE_RST = PS_W'(33);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH = 1'b0,
    CFG_PATCH_SIZE = 1'b1
  } cfg_idx_e;

  // rim side being walked, one-hot
  typedef enum logic [3:0] {
    SIDE_LEFT   = 4'b0001,
    SIDE_TOP    = 4'b0010,
    SIDE_RIGHT  = 4'b0100,
    SIDE_BOTTOM = 4'b1000
  } side_e;

  // one classified fan, ready for the triangle sequencer
  typedef struct packed {
    logic [IDX_W-1:0]  ctr;      // center vertex index
    logic [IDX_W-1:0]  base;     // lower left rim corner
    logic [IDX_W-1:0]  row_step; // core step times grid width
    logic [STEP_W-1:0] col_step; // core step
    logic              dbl_left;
    logic              dbl_top;
    logic              dbl_right;
    logic              dbl_bottom;
  } fan_cmd_t;

endpackage

// File: rtl/gfig_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfig_front: configuration registers and fan classification
// Registers the input with its row product, then works out the center,
// the rim base, the steps and the doubled sides of the fan.
// ----------------------------------------------------------------------------
module gfig_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gfig_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [gfig_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [gfig_pkg::OFS_W-1:0]     fan_x_i,
  input  logic [gfig_pkg::OFS_W-1:0]     fan_z_i,
  input  logic [gfig_pkg::LOD_W-1:0]     core_lod_i,
  input  logic [3:0]                     coarse_i,   // left, right, top, bottom
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output gfig_pkg::fan_cmd_t             cmd_o
);
  import gfig_pkg::*;

  logic [GW_W-1:0] grid_width_q;
  logic [PS_W-1:0] patch_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= GRID_WIDTH_RST;
      patch_size_q <= PATCH_SIZE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH: grid_width_q <= cfg_data_i[GW_W-1:0];
        CFG_PATCH_SIZE: patch_size_q <= cfg_data_i[PS_W-1:0];
        default: ;
      endcase
    end
  end

  logic              s1_valid_q, s1_valid_d;
  logic [IDX_W-1:0]  s1_zw_q;
  logic [OFS_W-1:0]  s1_x_q, s1_z_q;
  logic [LOD_W-1:0]  s1_lod_q;
  logic [3:0]        s1_coarse_q;
  logic [GW_W+OFS_W-1:0] prod;
  logic              in_fire, push;

  assign prod       = (GW_W+OFS_W)'(fan_z_i) * (GW_W+OFS_W)'(grid_width_q);
  assign push       = s1_valid_q && cmd_ready_i;
  assign in_ready_o = !s1_valid_q || cmd_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (push) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_zw_q     <= prod[IDX_W-1:0];
      s1_x_q      <= fan_x_i;
      s1_z_q      <= fan_z_i;
      s1_lod_q    <= core_lod_i;
      s1_coarse_q <= coarse_i;
    end
  end

  // classification of the registered fan
  logic [STEP_W-1:0]  sc;
  logic signed [11:0] end_pos;
  logic signed [11:0] x_s, z_s;
  logic [IDX_W-1:0]   base, row_step;

  assign sc       = STEP_W'(1) << s1_lod_q;
  assign end_pos  = $signed({3'b000, patch_size_q}) - 12'sd1
                  - $signed({3'b000, sc, 1'b0});
  assign x_s      = $signed({3'b000, s1_x_q});
  assign z_s      = $signed({3'b000, s1_z_q});
  assign base     = s1_zw_q + IDX_W'(s1_x_q);
  assign row_step = IDX_W'(grid_width_q) << s1_lod_q;

  always_comb begin
    cmd_o.ctr        = base + row_step + IDX_W'(sc);
    cmd_o.base       = base;
    cmd_o.row_step   = row_step;
    cmd_o.col_step   = sc;
    cmd_o.dbl_left   = s1_coarse_q[0] && (s1_x_q == '0);
    cmd_o.dbl_right  = s1_coarse_q[1] && (x_s == end_pos);
    cmd_o.dbl_top    = s1_coarse_q[2] && (z_s == end_pos);
    cmd_o.dbl_bottom = s1_coarse_q[3] && (s1_z_q == '0);
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

// File: rtl/gfig_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfig_fifo: short command queue
// Holds classified fans between the front and the triangle sequencer.
// ----------------------------------------------------------------------------
module gfig_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  gfig_pkg::fan_cmd_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output gfig_pkg::fan_cmd_t pop_data_o
);
  import gfig_pkg::*;

  fan_cmd_t         mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_AW:0]   count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/gfig_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfig_back: triangle sequencer
// Walks the fan rim into an output register, one triangle per unstalled cycle.
// ----------------------------------------------------------------------------
module gfig_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  gfig_pkg::fan_cmd_t         cmd_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [gfig_pkg::IDX_W-1:0] center_o,
  output logic [gfig_pkg::IDX_W-1:0] first_rim_o,
  output logic [gfig_pkg::IDX_W-1:0] second_rim_o,
  output logic                       last_o
);
  import gfig_pkg::*;

  side_e            side_q, side_d;
  logic             half_q, started_q;
  logic [IDX_W-1:0] cur_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] ctr_out_q, first_out_q, second_out_q;
  logic             last_out_q;

  logic             adv, dbl, vertical, rising, side_done, last;
  logic [IDX_W-1:0] cur, mag, next;

  assign adv = cmd_valid_i && (!out_valid_q || out_ready_i);
  assign cur = started_q ? cur_q : cmd_i.base;

  always_comb begin
    dbl      = 1'b0;
    vertical = 1'b0;
    rising   = 1'b0;
    side_d   = SIDE_LEFT;
    case (side_q)
      SIDE_LEFT: begin
        dbl = cmd_i.dbl_left;   vertical = 1'b1; rising = 1'b1; side_d = SIDE_TOP;
      end
      SIDE_TOP: begin
        dbl = cmd_i.dbl_top;    vertical = 1'b0; rising = 1'b1; side_d = SIDE_RIGHT;
      end
      SIDE_RIGHT: begin
        dbl = cmd_i.dbl_right;  vertical = 1'b1; rising = 1'b0; side_d = SIDE_BOTTOM;
      end
      SIDE_BOTTOM: begin
        dbl = cmd_i.dbl_bottom; vertical = 1'b0; rising = 1'b0; side_d = SIDE_LEFT;
      end
      default: begin
        side_d = SIDE_LEFT;
      end
    endcase
    mag = vertical ? cmd_i.row_step : IDX_W'(cmd_i.col_step);
    if (dbl) begin
      mag = mag << 1;
    end
    next      = rising ? cur + mag : cur - mag;
    side_done = dbl || half_q;
    last      = (side_q == SIDE_BOTTOM) && side_done;
  end

  assign cmd_ready_o = adv && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q      <= SIDE_LEFT;
      half_q      <= 1'b0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
      started_q   <= !last;
      if (side_done) begin
        side_q <= side_d;
        half_q <= 1'b0;
      end else begin
        half_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cur_q        <= next;
      ctr_out_q    <= cmd_i.ctr;
      first_out_q  <= cur;
      second_out_q <= next;
      last_out_q   <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign center_o     = ctr_out_q;
  assign first_rim_o  = first_out_q;
  assign second_rim_o = second_out_q;
  assign last_o       = last_out_q;

endmodule

// File: rtl/geomip_fan_index_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geomip_fan_index_generator: terrain fan triangle index generator
// Turns one fan cell description into four to eight triangles of vertex
// indices relative to the patch base.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one fan cell per transfer: offsets, core level of detail
//    and the four coarse-neighbor flags. m_axis carries one triangle per
//    transfer; tlast marks the final triangle of each fan.
//  - cfg_we_i writes grid_width (index 0) or patch_size (index 1);
//    write them only while no fan is in flight.
//  - The first triangle of a fan passes the input register, the queue and
//    the output register, in that order, before it leaves the block.
//  - Throughput: the sequencer emits one triangle per cycle while the output
//    is not stalled; a fan has 4 to 8 triangles: 8 minus one per doubled side.
//    Consecutive fans follow without gaps; the front and a two-entry queue
//    prefetch the next fans while the current one is emitted.
//  - Reset clears all valid state and restores grid_width = 257 and
//    patch_size = 33.
//  - When m_axis_tready_i is low the output register holds its triangle,
//    the sequencer halts, and the queue and front fill and then drop
//    s_axis_tready_o.
// ----------------------------------------------------------------------------
module geomip_fan_index_generator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [gfig_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gfig_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // fan input: fan_x[8:0], fan_z[17:9], core_lod[20:18], left_coarse[21],
  // right_coarse[22], top_coarse[23], bottom_coarse[24], zero[31:25]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [gfig_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // triangle output: center_vertex[20:0], first_rim_vertex[41:21],
  // second_rim_vertex[62:42], zero[63]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [gfig_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic                            m_axis_tlast_o
);
  import gfig_pkg::*;

  fan_cmd_t         front_cmd, queue_cmd;
  logic             front_valid, front_ready;
  logic             queue_valid, queue_ready;
  logic [IDX_W-1:0] center, first_rim, second_rim;

  // classify each fan as it arrives
  gfig_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .fan_x_i     (s_axis_tdata_i[8:0]),
    .fan_z_i     (s_axis_tdata_i[17:9]),
    .core_lod_i  (s_axis_tdata_i[20:18]),
    .coarse_i    (s_axis_tdata_i[24:21]),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready),
    .cmd_o       (front_cmd)
  );

  // decouple classification from triangle emission
  gfig_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_cmd)
  );

  // walk the rim, one triangle per transfer
  gfig_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (queue_valid),
    .cmd_ready_o  (queue_ready),
    .cmd_i        (queue_cmd),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .center_o     (center),
    .first_rim_o  (first_rim),
    .second_rim_o (second_rim),
    .last_o       (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, second_rim, first_rim, center};

endmodule

// File: rtl/gfig_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfig_checker: port-level checks of the fan index generator
// Tracks triangles of the current fan; checks stall holding, rim continuity,
// count, and that register writes land only while input and output are quiet.
// ----------------------------------------------------------------------------
module gfig_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [gfig_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tlast_o
);
  import gfig_pkg::*;

  logic             out_fire;
  logic             in_fire;
  logic             open_q;
  logic [2:0]       cnt_q;
  logic [IDX_W-1:0] prev_ctr_q, prev_second_q;

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      cnt_q  <= '0;
    end else if (out_fire) begin
      open_q <= !m_axis_tlast_o;
      cnt_q  <= m_axis_tlast_o ? 3'd0 : cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      prev_ctr_q    <= m_axis_tdata_o[IDX_W-1:0];
      prev_second_q <= m_axis_tdata_o[3*IDX_W-1:2*IDX_W];
    end
  end

  // stalled triangle holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("triangle changed while stalled");

  // each triangle of a fan starts where the previous one ended
  a_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && open_q |->
      m_axis_tdata_o[2*IDX_W-1:IDX_W] == prev_second_q &&
      m_axis_tdata_o[IDX_W-1:0] == prev_ctr_q)
    else $error("fan rim not continuous");

  // no fan longer than eight triangles
  a_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && cnt_q == 3'd7 |-> m_axis_tlast_o)
    else $error("fan exceeds eight triangles");

  // no fan shorter than four triangles
  a_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && m_axis_tlast_o |-> cnt_q >= 3'd3)
    else $error("fan shorter than four triangles");

  // register writes land only while no fan enters and no triangle is offered
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !in_fire && !m_axis_tvalid_o)
    else $error("register write while fans in flight");

endmodule

bind geomip_fan_index_generator gfig_checker u_gfig_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the terrain fan triangle index generator
// Fan cells are streamed in, mostly with random gaps and output back-pressure.
// Each accepted fan is expanded here into its four to eight triangles. Every
// triangle that leaves the block is compared field by field with the oldest
// one still owed. The run covers several grid and patch settings: the reset
// values, the smallest, the largest, random ones and out-of-range ones.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [gfig_pkg::IDX_W-1:0] center;
  logic [gfig_pkg::IDX_W-1:0] rim_a;
  logic [gfig_pkg::IDX_W-1:0] rim_b;
  logic                       last;
} fan_tri_t;

class fan_scoreboard;
  logic [gfig_pkg::GW_W-1:0] grid_width;
  logic [gfig_pkg::PS_W-1:0] patch_size;
  fan_tri_t                  owed_tris[$];
  int                        errors;

  function new();
    grid_width = gfig_pkg::GRID_WIDTH_RST;
    patch_size = gfig_pkg::PATCH_SIZE_RST;
    errors     = 0;
  endfunction

  function void set_reg(gfig_pkg::cfg_idx_e idx, logic [gfig_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      gfig_pkg::CFG_GRID_WIDTH: grid_width = value[gfig_pkg::GW_W-1:0];
      gfig_pkg::CFG_PATCH_SIZE: patch_size = value[gfig_pkg::PS_W-1:0];
      default: ;
    endcase
  endfunction

  function int owed();
    return owed_tris.size();
  endfunction

  // Walk the rim of one accepted fan: left side up, top right, right side
  // down, bottom left. A doubled side yields one triangle, else two.
  function void note_fan(logic [31:0] fan);
    logic [8:0]                 x, z;
    logic [2:0]                 lod;
    logic [3:0]                 dbl;
    longint unsigned            w, sc, step;
    longint                     far_pos;
    logic [gfig_pkg::IDX_W-1:0] ctr, rim, delta;
    fan_tri_t                   tri_item;
    x       = fan[8:0];
    z       = fan[17:9];
    lod     = fan[20:18];
    w       = grid_width;
    sc      = 64'd1 << lod;
    // right and top edge position; negative when the patch is too small
    far_pos = longint'(patch_size) - 1 - longint'(sc << 1);
    dbl[0]  = fan[21] && (x == 0);
    dbl[1]  = fan[23] && (longint'(z) == far_pos);
    dbl[2]  = fan[22] && (longint'(x) == far_pos);
    dbl[3]  = fan[24] && (z == 0);
    ctr     = gfig_pkg::IDX_W'((z + sc) * w + x + sc);
    rim     = gfig_pkg::IDX_W'(z * w + x);
    for (int s = 0; s < 4; s++) begin
      step  = dbl[s] ? (sc << 1) : sc;
      delta = (s == 0 || s == 2) ? gfig_pkg::IDX_W'(step * w) : gfig_pkg::IDX_W'(step);
      for (int k = 0; k < (dbl[s] ? 1 : 2); k++) begin
        tri_item.center = ctr;
        tri_item.rim_a  = rim;
        rim             = (s < 2) ? rim + delta : rim - delta;
        tri_item.rim_b  = rim;
        tri_item.last   = 1'b0;
        owed_tris.push_back(tri_item);
      end
    end
    owed_tris[owed_tris.size()-1].last = 1'b1;
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_triangle(logic [gfig_pkg::OUT_DATA_W-1:0] data, logic last);
    fan_tri_t want;
    if (owed_tris.size() == 0) begin
      report($sformatf("triangle with none owed: data=%h last=%b", data, last));
      return;
    end
    want = owed_tris.pop_front();
    if (data[20:0] !== want.center)
      report($sformatf("center_vertex %0d, want %0d", data[20:0], want.center));
    if (data[41:21] !== want.rim_a)
      report($sformatf("first_rim_vertex %0d, want %0d", data[41:21], want.rim_a));
    if (data[62:42] !== want.rim_b)
      report($sformatf("second_rim_vertex %0d, want %0d", data[62:42], want.rim_b));
    if (last !== want.last)
      report($sformatf("last_triangle %b, want %b", last, want.last));
  endtask
endclass

module tb_top;
  import gfig_pkg::*;

  // cycles without any transfer or register write before the run is abandoned;
  // the longest legal quiet stretch is the receiver hold-off below
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;

  logic tx_idle_en;    // sender inserts random gaps
  logic rx_idle_en;    // receiver drops ready at random
  logic hold_request;  // ask the receiver for one long hold-off
  int   quiet_cycles;

  fan_scoreboard sb = new();

  geomip_fan_index_generator uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #1 clk_i = ~clk_i;

  // Pack one fan cell into the input word, fan_x in the lowest bits.
  function automatic logic [31:0] make_fan(int x, int z, int lod, bit lc, bit rc, bit tc,
                                           bit bc);
    logic [8:0] xv, zv;
    logic [2:0] lv;
    xv = x[8:0];
    zv = z[8:0];
    lv = lod[2:0];
    return {7'b0, bc, tc, rc, lc, lv, zv, xv};
  endfunction

  // Offset along one axis: the low edge, the high edge or any aligned cell.
  function automatic int pick_offset(int step, int far_pos);
    case ($urandom_range(2))
      0:       return 0;
      1:       return far_pos;
      default: return step * $urandom_range(0, far_pos / step);
    endcase
  endfunction

  // Mostly well-formed fans for the current patch size, so edge matches and
  // doubled sides come up often; the rest is unconstrained noise.
  function automatic logic [31:0] random_fan();
    int ps, max_lod, lod, step, far_pos;
    ps = sb.patch_size;
    if (ps < 3 || $urandom_range(9) == 0)
      return make_fan($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 7),
                      $urandom_range(1), $urandom_range(1), $urandom_range(1),
                      $urandom_range(1));
    max_lod = 0;
    while (max_lod < 7 && (4 << max_lod) <= ps - 1) max_lod++;
    lod     = $urandom_range(0, max_lod);
    step    = 2 << lod;
    far_pos = ps - 1 - step;
    return make_fan(pick_offset(step, far_pos), pick_offset(step, far_pos), lod,
                    $urandom_range(1), $urandom_range(1), $urandom_range(1),
                    $urandom_range(1));
  endfunction

  // Offer one fan and hold it until the block takes it. Enter and leave at
  // a falling edge; valid stays high so back-to-back fans need no gap.
  task automatic send_fan(logic [31:0] fan);
    if (tx_idle_en)
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid_i = 1'b0;
        @(negedge clk_i);
      end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = fan;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_fan(fan);
    @(negedge clk_i);
  endtask

  task automatic send_random(int count);
    repeat (count) send_fan(random_fan());
  endtask

  // Stop offering and wait until every owed triangle has come out, then
  // let the pipeline settle before touching registers.
  task automatic drain();
    s_axis_tvalid_i = 1'b0;
    while (sb.owed() > 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = value;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
    sb.set_reg(idx, value);
  endtask

  // Receiver: random ready, a long hold-off on request, or always ready.
  initial begin
    int hold_left;
    hold_left       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request <= 1'b0;
      end
      if (hold_left > 0) begin
        m_axis_tready_i = 1'b0;
        hold_left--;
      end else if (rx_idle_en) begin
        m_axis_tready_i = ($urandom_range(99) >= 30);
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Check every triangle transfer and watch for a stuck run.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_triangle(m_axis_tdata_o, m_axis_tlast_o);
    if (!rst_ni || cfg_we_i || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_GRID_WIDTH;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    tx_idle_en      = 1'b1;
    rx_idle_en      = 1'b1;
    hold_request    = 1'b0;
    quiet_cycles    = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed fans at the reset settings: grid 257, patch 33.
    send_fan(make_fan(0, 0, 0, 0, 0, 0, 0));       // interior, eight triangles
    send_fan(make_fan(0, 0, 0, 1, 1, 1, 1));       // left and bottom doubled
    send_fan(make_fan(30, 30, 0, 1, 1, 1, 1));     // right and top doubled
    send_fan(make_fan(2, 2, 0, 1, 1, 1, 1));       // flags set off every edge
    send_fan(make_fan(0, 30, 0, 1, 0, 0, 0));      // left side only
    send_fan(make_fan(30, 0, 0, 0, 1, 0, 0));      // right side only
    send_fan(make_fan(4, 30, 0, 0, 0, 1, 0));      // top side only
    send_fan(make_fan(4, 0, 0, 0, 0, 0, 1));       // bottom side only
    send_fan(make_fan(16, 16, 3, 1, 1, 1, 1));     // coarser step on far edges
    send_fan(make_fan(0, 0, 4, 1, 1, 1, 1));       // one cell per patch, four triangles
    send_fan(make_fan(0, 0, 4, 0, 1, 1, 0));       // far edges at offset zero
    send_fan(make_fan(0, 0, 5, 1, 1, 1, 1));       // step exceeds the patch
    send_fan(make_fan(0, 0, 7, 1, 1, 1, 1));       // largest step, patch too small
    send_fan(make_fan(256, 256, 7, 0, 0, 0, 0));   // largest offsets in range
    send_fan(make_fan(511, 511, 7, 1, 1, 1, 1));   // every offset bit set
    send_fan(make_fan(16, 8, 5, 1, 1, 1, 1));      // unaligned offsets
    drain();

    // Random fans at the reset settings; halfway the receiver holds off long
    // enough for the block to back up and stall its input.
    send_random(20);
    hold_request <= 1'b1;
    send_random(20);
    drain();

    // Smallest grid and patch, with neither side idling.
    write_reg(CFG_GRID_WIDTH, 13'd3);
    write_reg(CFG_PATCH_SIZE, 13'd3);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(30);
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;

    // Largest grid and patch; pause the input until the block has emptied.
    write_reg(CFG_GRID_WIDTH, 13'd4097);
    write_reg(CFG_PATCH_SIZE, 13'd257);
    send_random(30);
    drain();
    send_random(30);
    drain();

    // Random legal settings.
    repeat (3) begin
      write_reg(CFG_GRID_WIDTH, 13'($urandom_range(3, 4097)));
      write_reg(CFG_PATCH_SIZE, 13'(2 * $urandom_range(1, 128) + 1));
      send_random(40);
      drain();
    end

    // Random register values, often outside their range, upper data bits included.
    write_reg(CFG_GRID_WIDTH, 13'($urandom_range(0, 8191)));
    write_reg(CFG_PATCH_SIZE, 13'($urandom_range(0, 8191)));
    send_random(20);
    drain();

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gfig_pkg.sv
rtl/gfig_front.sv
rtl/gfig_fifo.sv
rtl/gfig_back.sv
rtl/geomip_fan_index_generator.sv
rtl/gfig_checker.sv
test/tb_top.sv
